[design/jsu_pkg.sv]
package jsu_pkg;

    // Scanner position, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_BODY = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } t_mode;

    // Scanner state carried from one word to the next
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_count;
        logic [15:0] hex_accum;
        logic        hex_seen;
        logic        hex_stopped;
        logic [15:0] prev_code;
    } t_scan;

    // Group of output bytes caused by one input word
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
        logic            err;
    } t_group;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [15:0] CODE_2BYTE = 16'h0080;
    localparam logic [15:0] CODE_3BYTE = 16'h0800;
    localparam logic [15:0] CODE_NONE  = 16'hFFFF;

    localparam logic [7:0] UTF_LEAD2 = 8'b1100_0000;
    localparam logic [7:0] UTF_LEAD3 = 8'b1110_0000;
    localparam logic [7:0] UTF_CONT  = 8'b1000_0000;

endpackage

[design/jsu_decode.sv]
module jsu_decode (
    input  jsu_pkg::t_scan  i_scan,
    input  logic [7:0]      i_byte,
    input  logic            i_eoi,
    output jsu_pkg::t_scan  o_scan,
    output jsu_pkg::t_group o_group
);
    import jsu_pkg::*;

    // Decode one hex character; bit 4 flags a valid digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            v = {1'b1, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Turn a code point into escaped or UTF-8 bytes
    function automatic t_group emit_code(input logic [15:0] c);
        t_group g;
        g = '0;
        priority if (c == {8'h00, CH_QUOTE} || c == {8'h00, CH_BSLASH}) begin
            g.cnt = 2'd2; g.data[0] = CH_BSLASH; g.data[1] = c[7:0];
        end else if (c == {8'h00, CH_LF}) begin
            g.cnt = 2'd2; g.data[0] = CH_BSLASH; g.data[1] = CH_N;
        end else if (c == {8'h00, CH_CR}) begin
            g.cnt = 2'd2; g.data[0] = CH_BSLASH; g.data[1] = CH_R;
        end else if (c == {8'h00, CH_TAB}) begin
            g.cnt = 2'd2; g.data[0] = CH_BSLASH; g.data[1] = CH_T;
        end else if (c < CODE_2BYTE) begin
            g.cnt = 2'd1; g.data[0] = c[7:0];
        end else if (c < CODE_3BYTE) begin
            g.cnt = 2'd2;
            g.data[0] = UTF_LEAD2 | {3'b000, c[10:6]};
            g.data[1] = UTF_CONT | {2'b00, c[5:0]};
        end else if (c != CODE_NONE) begin
            g.cnt = 2'd3;
            g.data[0] = UTF_LEAD3 | {4'b0000, c[15:12]};
            g.data[1] = UTF_CONT | {2'b00, c[11:6]};
            g.data[2] = UTF_CONT | {2'b00, c[5:0]};
        end else begin
            g.cnt = 2'd0;
        end
        return g;
    endfunction

    logic [4:0]  digit;
    logic [15:0] accum_n;
    logic        seen_n;
    logic        stopped_n;
    logic [15:0] code;

    // Fold the current byte into the hex accumulator
    always_comb begin
        digit     = hex_value(i_byte);
        accum_n   = (!i_scan.hex_stopped && digit[4]) ?
                    {i_scan.hex_accum[11:0], digit[3:0]} : i_scan.hex_accum;
        seen_n    = i_scan.hex_seen | (!i_scan.hex_stopped & digit[4]);
        stopped_n = i_scan.hex_stopped | !digit[4];
        code      = seen_n ? accum_n : i_scan.prev_code;
    end

    // Advance the scanner and build the output group
    always_comb begin
        o_scan  = i_scan;
        o_group = '0;
        if (i_eoi) begin
            if (i_scan.mode != MODE_IDLE) begin
                o_group.cnt       = 2'd1;
                o_group.err       = 1'b1;
                o_scan.mode       = MODE_IDLE;
                o_scan.hex_count  = '0;
                o_scan.hex_accum  = '0;
                o_scan.hex_seen   = 1'b0;
                o_scan.hex_stopped = 1'b0;
            end
        end else begin
            unique case (i_scan.mode)
                MODE_IDLE: begin
                    if (i_byte == CH_QUOTE) begin
                        o_group.cnt        = 2'd1;
                        o_group.data[0]    = CH_QUOTE;
                        o_scan.mode        = MODE_BODY;
                        o_scan.prev_code   = '0;
                        o_scan.hex_count   = '0;
                        o_scan.hex_accum   = '0;
                        o_scan.hex_seen    = 1'b0;
                        o_scan.hex_stopped = 1'b0;
                    end
                end
                MODE_BODY: begin
                    if (i_byte == CH_QUOTE) begin
                        o_group.cnt     = 2'd2;
                        o_group.data[0] = CH_QUOTE;
                        o_group.data[1] = CH_LF;
                        o_scan.mode     = MODE_IDLE;
                    end else if (i_byte == CH_BSLASH) begin
                        o_scan.mode = MODE_ESC;
                    end else begin
                        o_group.cnt     = 2'd1;
                        o_group.data[0] = i_byte;
                    end
                end
                MODE_ESC: begin
                    if (i_byte == CH_U) begin
                        o_scan.mode        = MODE_HEX;
                        o_scan.hex_count   = '0;
                        o_scan.hex_accum   = '0;
                        o_scan.hex_seen    = 1'b0;
                        o_scan.hex_stopped = 1'b0;
                    end else begin
                        o_scan.mode = MODE_BODY;
                        if (i_byte == CH_SLASH || i_byte == CH_QUOTE) begin
                            o_group.cnt     = 2'd1;
                            o_group.data[0] = i_byte;
                        end else begin
                            o_group.cnt     = 2'd2;
                            o_group.data[0] = CH_BSLASH;
                            o_group.data[1] = i_byte;
                        end
                    end
                end
                MODE_HEX: begin
                    if (i_scan.hex_count == 2'd3) begin
                        o_group            = emit_code(code);
                        o_scan.prev_code   = code;
                        o_scan.mode        = MODE_BODY;
                        o_scan.hex_count   = '0;
                        o_scan.hex_accum   = '0;
                        o_scan.hex_seen    = 1'b0;
                        o_scan.hex_stopped = 1'b0;
                    end else begin
                        o_scan.hex_count   = i_scan.hex_count + 2'd1;
                        o_scan.hex_accum   = accum_n;
                        o_scan.hex_seen    = seen_n;
                        o_scan.hex_stopped = stopped_n;
                    end
                end
                default: begin
                    o_scan.mode = MODE_IDLE;
                end
            endcase
        end
    end

endmodule

[design/json_string_unescape.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_in_byte, i_end_of_input
// out      | output    | o_out_valid / i_out_ready  | o_out_byte, o_last, o_error
//
// One input word is decoded in the cycle it is accepted; its 0 to 3 output bytes
// sit in a result register and leave one per cycle while i_out_ready is high.
// The result register drains a single byte per cycle when the output is not stalled.
// A new word is taken while the last byte of the previous group is being taken.
// Synchronous active-low reset returns the scanner to idle outside any string.
// Stalls on the output hold the result register and stop input acceptance.
module json_string_unescape (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_error
);
    import jsu_pkg::*;

    t_scan           r_scan;
    t_scan           n_scan;
    t_group          n_group;
    logic [1:0]      r_cnt;
    logic [2:0][7:0] r_data;
    logic            r_err;
    logic            in_fire;
    logic            out_fire;

    jsu_decode u_decode (
        .i_scan  (r_scan),
        .i_byte  (i_in_byte),
        .i_eoi   (i_end_of_input),
        .o_scan  (n_scan),
        .o_group (n_group)
    );

    // Handshakes
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_last      = (r_cnt == 2'd1);
    assign o_out_byte  = r_data[0];
    assign o_error     = r_err;
    assign out_fire    = o_out_valid & i_out_ready;
    assign o_in_ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign in_fire     = i_in_valid & o_in_ready;

    // Advance scanner state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.mode        <= MODE_IDLE;
            r_scan.hex_count   <= '0;
            r_scan.hex_accum   <= '0;
            r_scan.hex_seen    <= 1'b0;
            r_scan.hex_stopped <= 1'b0;
            r_scan.prev_code   <= '0;
        end else if (in_fire) begin
            r_scan <= n_scan;
        end
    end

    // Load a new group, or shift out the byte just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_fire) begin
            r_cnt <= n_group.cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data <= n_group.data;
            r_err  <= n_group.err;
        end else if (out_fire) begin
            r_data <= {8'h00, r_data[2], r_data[1]};
        end
    end

`ifndef NO_ASSERTIONS
    // An error word stands alone in its group
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> o_last)
        else $error("error byte not marked last");

    // After an error the scanner is back outside any string
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (r_scan.mode == MODE_IDLE))
        else $error("error result while scanner inside a string");

    // Hex counting only runs inside a unicode escape
    a_hex_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan.hex_count != 2'd0) |-> (r_scan.mode == MODE_HEX))
        else $error("hex count set outside unicode escape");

    // Taking the last byte with no new word empties the output
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_last && !in_fire) |=> !o_out_valid)
        else $error("output still valid after group drained");
`endif

endmodule
